// ----- rtl/core/gbgc_pkg.sv -----
// Shared types, register indexes and constants of the grid ground classifier.
`timescale 1ns / 1ps
`default_nettype none
package gbgc_pkg;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 128;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ORIGIN_X   = 3'd0;
  localparam cfg_idx_t CFG_ORIGIN_Z   = 3'd1;
  localparam cfg_idx_t CFG_INV_STEP_X = 3'd2;
  localparam cfg_idx_t CFG_INV_STEP_Z = 3'd3;
  localparam cfg_idx_t CFG_THRESHOLD  = 3'd4;
  localparam cfg_idx_t CFG_GRID_COLS  = 3'd5;
  localparam cfg_idx_t CFG_GRID_ROWS  = 3'd6;

  localparam logic [30:0] INV_STEP_RST  = 31'd65536;
  localparam logic [30:0] THRESHOLD_RST = 31'd32768;
  localparam logic [7:0]  GRID_DIM_RST  = 8'd128;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  typedef struct packed {
    logic               action;
    logic [6:0]         cell_col;
    logic [6:0]         cell_row;
    logic signed [31:0] cell_height;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0]        point_tag;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        result_tag;
    logic               is_ground;
    logic               out_of_grid;
    logic signed [31:0] height_diff;
  } out_word_t;

  // one axis of the cell lookup
  typedef struct packed {
    logic        ok;
    logic [31:0] idx;
    logic [15:0] frac;
  } axis_loc_t;

endpackage
`default_nettype wire

// ----- rtl/core/gbgc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gbgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/gbgc_axis.sv -----
// Cell index, fraction and range check along one grid axis.
`timescale 1ns / 1ps
`default_nettype none
module gbgc_axis #(
  parameter int MAXN = gbgc_pkg::MAX_COLS_DEF
) (
  input  wire logic signed [63:0] u,
  input  wire logic [7:0]         used,
  output gbgc_pkg::axis_loc_t     loc
);

  localparam int NW = $clog2(MAXN + 1);
  localparam int CW = (NW > 8) ? NW : 8;

  logic [CW-1:0] used_w;
  logic [CW-1:0] max_w;
  logic [CW-1:0] n;
  logic [31:0]   i;

  always_comb begin
    used_w = CW'(used);
    max_w  = CW'(MAXN);
    n      = (used_w > max_w) ? max_w : used_w;
    i      = u[63:32];
    loc.ok   = !u[63] && (n >= CW'(2)) && (({1'b0, i} + 33'd1) < 33'(n));
    loc.idx  = i;
    loc.frac = u[31:16];
  end

endmodule
`default_nettype wire

// ----- rtl/core/gbgc_lerp.sv -----
// Exact linear blend of two heights by a Q0.16 fraction.
`timescale 1ns / 1ps
`default_nettype none
module gbgc_lerp (
  input  wire logic signed [31:0] h0,
  input  wire logic signed [31:0] h1,
  input  wire logic [15:0]        frac,
  output logic signed [48:0]      y
);

  logic signed [49:0] w1;
  logic signed [49:0] w0;
  logic signed [49:0] p0;
  logic signed [49:0] p1;

  always_comb begin
    w1 = $signed({34'd0, frac});
    w0 = 50'sd65536 - w1;
    p0 = 50'(h0) * w0;
    p1 = 50'(h1) * w1;
    y  = 49'(p0 + p1);
  end

endmodule
`default_nettype wire

// ----- rtl/core/grid_bilinear_ground_classifier.sv -----
// Top level: pipelined bilinear cloth-height lookup and ground test.
//
//  channel | ports                           | word
//  --------+---------------------------------+------------------------------
//  in      | in_valid / in_ready / in_data   | height write or point
//  out     | out_valid / out_ready / out_data| one result per point
//  cfg     | cfg_we / cfg_index / cfg_wdata  | register write, no wait
//
// One word per cycle sustained while out_ready stays high; each stage below
// ends in a register.
// Stages: input reg, origin subtract, scale multiply, cell lookup + bank read,
// row blend, blend prep, column blend + round, difference/saturate (out reg).
// The grid lives in four RAM banks by column/row parity, so the four corners
// are read in the same cycle. Height writes update the banks at the lookup stage and
// produce no result. Each stage loads when it is empty or its successor moves,
// so a stall only holds words in place. Reset (rst_n low, synchronous) clears
// valid bits and config; grid contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module grid_bilinear_ground_classifier #(
  parameter int MAX_COLS = gbgc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gbgc_pkg::MAX_ROWS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gbgc_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output gbgc_pkg::out_word_t      out_data,
  input  wire logic                cfg_we,
  input  wire gbgc_pkg::cfg_idx_t  cfg_index,
  input  wire logic [31:0]         cfg_wdata
);

  localparam int CIW        = $clog2(MAX_COLS);
  localparam int RIW        = $clog2(MAX_ROWS);
  localparam int HALF_C     = (MAX_COLS + 1) / 2;
  localparam int HALF_R     = (MAX_ROWS + 1) / 2;
  localparam int BANK_DEPTH = HALF_C * HALF_R;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // configuration
  logic signed [31:0] origin_x_r, origin_z_r;
  logic [30:0]        inv_step_x_r, inv_step_z_r, threshold_r;
  logic [7:0]         grid_cols_r, grid_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_z_r   <= '0;
      inv_step_x_r <= gbgc_pkg::INV_STEP_RST;
      inv_step_z_r <= gbgc_pkg::INV_STEP_RST;
      threshold_r  <= gbgc_pkg::THRESHOLD_RST;
      grid_cols_r  <= gbgc_pkg::GRID_DIM_RST;
      grid_rows_r  <= gbgc_pkg::GRID_DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbgc_pkg::CFG_ORIGIN_X:   origin_x_r   <= cfg_wdata;
        gbgc_pkg::CFG_ORIGIN_Z:   origin_z_r   <= cfg_wdata;
        gbgc_pkg::CFG_INV_STEP_X: inv_step_x_r <= cfg_wdata[30:0];
        gbgc_pkg::CFG_INV_STEP_Z: inv_step_z_r <= cfg_wdata[30:0];
        gbgc_pkg::CFG_THRESHOLD:  threshold_r  <= cfg_wdata[30:0];
        gbgc_pkg::CFG_GRID_COLS:  grid_cols_r  <= cfg_wdata[7:0];
        gbgc_pkg::CFG_GRID_ROWS:  grid_rows_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // stage valids and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en6, en7, en8;
  gbgc_pkg::in_word_t p1_r, p2_r, p3_r;

  assign en8 = !out_valid_r || out_ready;
  assign en7 = !v7_r || en8;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      // writes retire at the lookup stage
      if (en4) v4_r <= v3_r && (p3_r.action == gbgc_pkg::ACT_POINT);
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
      if (en8) out_valid_r <= v7_r;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (en1) p1_r <= in_data;
  end

  // stage 2: offset from origin
  logic signed [32:0] dx2_r, dz2_r;
  always_ff @(posedge clk) begin
    if (en2) begin
      p2_r  <= p1_r;
      dx2_r <= 33'(p1_r.point_x) - 33'(origin_x_r);
      dz2_r <= 33'(p1_r.point_z) - 33'(origin_z_r);
    end
  end

  // stage 3: scale to grid units, Q.32
  logic signed [63:0] ux3_r, uz3_r;
  always_ff @(posedge clk) begin
    if (en3) begin
      p3_r  <= p2_r;
      ux3_r <= 64'(dx2_r) * $signed({33'd0, inv_step_x_r});
      uz3_r <= 64'(dz2_r) * $signed({33'd0, inv_step_z_r});
    end
  end

  // stage 4: cell lookup, bank reads and height writes
  gbgc_pkg::axis_loc_t locx, locz;

  gbgc_axis #(.MAXN(MAX_COLS)) u_axis_x (.u(ux3_r), .used(grid_cols_r), .loc(locx));
  gbgc_axis #(.MAXN(MAX_ROWS)) u_axis_z (.u(uz3_r), .used(grid_rows_r), .loc(locz));

  logic [CIW-1:0] cidx;
  logic [RIW-1:0] ridx;
  logic [CIW:0]   cidx_p1;
  logic [RIW:0]   ridx_p1;
  logic           wr_hit;
  logic [1:0]     wr_bank;
  logic [BAW-1:0] wr_addr;

  always_comb begin
    cidx    = locx.idx[CIW-1:0];
    ridx    = locz.idx[RIW-1:0];
    cidx_p1 = {1'b0, cidx} + (CIW+1)'(1);
    ridx_p1 = {1'b0, ridx} + (RIW+1)'(1);
    wr_hit  = v3_r && (p3_r.action == gbgc_pkg::ACT_WRITE)
              && (32'(p3_r.cell_col) < 32'(MAX_COLS))
              && (32'(p3_r.cell_row) < 32'(MAX_ROWS));
    wr_bank = {p3_r.cell_row[0], p3_r.cell_col[0]};
    wr_addr = BAW'(p3_r.cell_row >> 1) * BAW'(HALF_C) + BAW'(p3_r.cell_col >> 1);
  end

  logic [31:0] bank_rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [CIW:0]   col_b;
    logic [RIW:0]   row_b;
    logic [BAW-1:0] rd_addr;
    logic           wr_en;

    always_comb begin
      col_b   = (cidx[0] == b[0]) ? {1'b0, cidx} : cidx_p1;
      row_b   = (ridx[0] == b[1]) ? {1'b0, ridx} : ridx_p1;
      rd_addr = BAW'(row_b >> 1) * BAW'(HALF_C) + BAW'(col_b >> 1);
      wr_en   = en4 && wr_hit && (wr_bank == 2'(b));
    end

    gbgc_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_ram (
      .clk  (clk),
      .we   (wr_en),
      .waddr(wr_addr),
      .wdata(p3_r.cell_height),
      .re   (en4),
      .raddr(rd_addr),
      .rdata(bank_rd[b])
    );
  end

  logic               ok4_r, c0_4_r, r0_4_r;
  logic [15:0]        fx4_r, fz4_r, tag4_r;
  logic signed [31:0] y4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      ok4_r  <= locx.ok && locz.ok;
      c0_4_r <= cidx[0];
      r0_4_r <= ridx[0];
      fx4_r  <= locx.frac;
      fz4_r  <= locz.frac;
      y4_r   <= p3_r.point_y;
      tag4_r <= p3_r.point_tag;
    end
  end

  // stage 5: blend along x for both rows
  logic signed [31:0] h00, h10, h01, h11;
  logic signed [48:0] row_a, row_b;

  always_comb begin
    h00 = bank_rd[{r0_4_r, c0_4_r}];
    h10 = bank_rd[{r0_4_r, !c0_4_r}];
    h01 = bank_rd[{!r0_4_r, c0_4_r}];
    h11 = bank_rd[{!r0_4_r, !c0_4_r}];
  end

  gbgc_lerp u_lerp_a (.h0(h00), .h1(h10), .frac(fx4_r), .y(row_a));
  gbgc_lerp u_lerp_b (.h0(h01), .h1(h11), .frac(fx4_r), .y(row_b));

  logic signed [48:0] a5_r, b5_r;
  logic               ok5_r, ok6_r, ok7_r;
  logic [15:0]        fz5_r, fz6_r, tag5_r, tag6_r, tag7_r;
  logic signed [31:0] y5_r, y6_r, y7_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      a5_r   <= row_a;
      b5_r   <= row_b;
      ok5_r  <= ok4_r;
      fz5_r  <= fz4_r;
      y5_r   <= y4_r;
      tag5_r <= tag4_r;
    end
  end

  // stage 6: row difference
  logic signed [48:0] a6_r;
  logic signed [49:0] dab6_r;
  always_ff @(posedge clk) begin
    if (en6) begin
      a6_r   <= a5_r;
      dab6_r <= 50'(b5_r) - 50'(a5_r);
      ok6_r  <= ok5_r;
      fz6_r  <= fz5_r;
      y6_r   <= y5_r;
      tag6_r <= tag5_r;
    end
  end

  // stage 7: blend along z in Q.48, round half up to Q.16
  logic signed [67:0] fsum, frnd;
  logic signed [33:0] h7_r;
  always_comb begin
    fsum = (68'(a6_r) <<< 16) + 68'(dab6_r) * $signed({52'd0, fz6_r});
    frnd = fsum + 68'sd2147483648;
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      h7_r   <= 34'(frnd >>> 32);
      ok7_r  <= ok6_r;
      y7_r   <= y6_r;
      tag7_r <= tag6_r;
    end
  end

  // stage 8: difference, ground test, saturation
  logic signed [34:0] diff, mag;
  gbgc_pkg::out_word_t res;
  always_comb begin
    diff = 35'(h7_r) - 35'(y7_r);
    mag  = (diff < 0) ? -diff : diff;
    res.result_tag  = tag7_r;
    res.out_of_grid = !ok7_r;
    res.is_ground   = ok7_r && (mag < $signed({4'd0, threshold_r}));
    if (!ok7_r) begin
      res.height_diff = '0;
    end else if (diff > 35'sd2147483647) begin
      res.height_diff = 32'sh7FFFFFFF;
    end else if (diff < -35'sd2147483648) begin
      res.height_diff = 32'sh80000000;
    end else begin
      res.height_diff = diff[31:0];
    end
  end

  gbgc_pkg::out_word_t out_r;
  always_ff @(posedge clk) begin
    if (en8) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_oog_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.out_of_grid || (!out_data.is_ground
                   && out_data.height_diff == 32'sd0)))
    else $error("out-of-grid result carries ground flag or difference");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_lookup_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !en4) |=> (v3_r && $stable(ux3_r) && $stable(uz3_r)))
    else $error("lookup stage word lost during stall");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en4 && v3_r && p3_r.action == gbgc_pkg::ACT_WRITE) |=> !v4_r)
    else $error("height write produced a result slot");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the grid bilinear ground classifier.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import gbgc_pkg::*;

  // Side of the preloaded grid region. Targeted points land inside it.
  localparam int REGION = 12;
  localparam int NCELLS = MAX_COLS_DEF * MAX_ROWS_DEF;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 5000;
  // Pipeline depth is 8; allow a little slack after the last result.
  localparam int DRAIN_CYCLES = 12;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  logic [31:0] cfg_wdata;

  grid_bilinear_ground_classifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ------------------------------------------------------------------
  // Shadow state: our own copy of the cloth grid and the registers.
  // ------------------------------------------------------------------
  logic signed [31:0] cloth_h [NCELLS];
  bit                 cloth_set [NCELLS];
  logic signed [31:0] sh_org_x, sh_org_z;
  logic [30:0]        sh_inv_x, sh_inv_z, sh_thr;
  logic [7:0]         sh_cols, sh_rows;

  out_word_t pending_results[$];

  int  errors;
  int  n_points, n_writes, n_results, n_oog, n_ground;
  bit  calm;        // last part of the run: no idling on either side
  bit  hold_req;    // asks the receiver for one long hold-off
  int  quiet_cycles;

  // Locate a point along one axis: cell index and Q0.16 fraction.
  function automatic bit axis_find(input logic signed [31:0] p,
                                   input logic signed [31:0] org,
                                   input logic [30:0] inv, input logic [7:0] used,
                                   input int maxn, output int idx,
                                   output longint frac);
    longint d, u, i;
    int     n;
    d = longint'(p) - longint'(org);
    u = d * longint'({33'b0, inv});
    n = (int'(used) > maxn) ? maxn : int'(used);
    idx  = 0;
    frac = 0;
    if (u < 0) return 1'b0;
    i = u >>> 32;
    if (n < 2 || i + 1 >= n) return 1'b0;
    idx  = int'(i);
    frac = (u >>> 16) & 64'hFFFF;
    return 1'b1;
  endfunction

  // Bilinear cloth height at the point minus its y, plus the ground decision.
  // Height writes update the shadow grid and yield no result.
  function automatic bit classify(input in_word_t w, output out_word_t r);
    int     c, rw;
    longint fx, fz, c00, c10, c01, c11, a, b, f, h, diff, mag;
    bit     ok;
    r = '0;
    if (w.action == ACT_WRITE) begin
      cloth_h[{w.cell_row, w.cell_col}]   = w.cell_height;
      cloth_set[{w.cell_row, w.cell_col}] = 1'b1;
      return 1'b0;
    end
    r.result_tag = w.point_tag;
    ok = axis_find(w.point_x, sh_org_x, sh_inv_x, sh_cols, MAX_COLS_DEF, c, fx);
    if (ok) ok = axis_find(w.point_z, sh_org_z, sh_inv_z, sh_rows, MAX_ROWS_DEF, rw, fz);
    if (!ok) begin
      r.out_of_grid = 1'b1;
      return 1'b1;
    end
    c00 = longint'(cloth_h[rw * MAX_COLS_DEF + c]);
    c10 = longint'(cloth_h[rw * MAX_COLS_DEF + c + 1]);
    c01 = longint'(cloth_h[(rw + 1) * MAX_COLS_DEF + c]);
    c11 = longint'(cloth_h[(rw + 1) * MAX_COLS_DEF + c + 1]);
    a = c00 * (65536 - fx) + c10 * fx;
    b = c01 * (65536 - fx) + c11 * fx;
    f = a * (65536 - fz) + b * fz;
    h = (f + (64'sd1 <<< 31)) >>> 32;   // round half up to Q15.16
    diff = h - longint'(w.point_y);
    mag  = (diff < 0) ? -diff : diff;
    r.is_ground = (mag < longint'({33'b0, sh_thr}));
    if (diff > 64'sd2147483647) diff = 64'sd2147483647;
    if (diff < -64'sd2147483648) diff = -64'sd2147483648;
    r.height_diff = diff[31:0];
    return 1'b1;
  endfunction

  // True when a point would not touch an unwritten cell.
  function automatic bit corners_known(input in_word_t w);
    int     c, rw;
    longint fx, fz;
    if (w.action == ACT_WRITE) return 1'b1;
    if (!axis_find(w.point_x, sh_org_x, sh_inv_x, sh_cols, MAX_COLS_DEF, c, fx)) return 1'b1;
    if (!axis_find(w.point_z, sh_org_z, sh_inv_z, sh_rows, MAX_ROWS_DEF, rw, fz)) return 1'b1;
    return cloth_set[rw * MAX_COLS_DEF + c] && cloth_set[rw * MAX_COLS_DEF + c + 1] &&
           cloth_set[(rw + 1) * MAX_COLS_DEF + c] &&
           cloth_set[(rw + 1) * MAX_COLS_DEF + c + 1];
  endfunction

  // Coordinate that maps near cell idx for the given origin and step.
  function automatic logic signed [31:0] aim(input logic signed [31:0] org,
                                            input logic [30:0] inv, input int idx);
    longint t, d;
    if (inv == 0) return $urandom;
    t = (longint'(idx) <<< 32) + longint'({32'b0, $urandom});
    d = t / longint'({33'b0, inv});
    return 32'(longint'(org) + d);
  endfunction

  function automatic in_word_t mk_wr(input int col, input int row,
                                     input logic [31:0] hgt);
    in_word_t w;
    w = '0;
    w.action      = ACT_WRITE;
    w.cell_col    = col[6:0];
    w.cell_row    = row[6:0];
    w.cell_height = hgt;
    return w;
  endfunction

  function automatic in_word_t mk_pt(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z, input logic [15:0] tag);
    in_word_t w;
    w = '0;
    w.action    = ACT_POINT;
    w.point_x   = x;
    w.point_y   = y;
    w.point_z   = z;
    w.point_tag = tag;
    return w;
  endfunction

  function automatic out_word_t mk_res(input logic [15:0] tag, input logic gnd,
                                       input logic oog, input logic [31:0] diff);
    out_word_t r;
    r.result_tag  = tag;
    r.is_ground   = gnd;
    r.out_of_grid = oog;
    r.height_diff = diff;
    return r;
  endfunction

  function automatic logic [31:0] rand_height();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  // One random word: height writes, targeted points and raw points.
  function automatic in_word_t next_word();
    in_word_t w;
    int       cx, cz, k;
    longint   base;
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 9) == 0)
        return mk_wr($urandom_range(0, 127), $urandom_range(0, 127), rand_height());
      return mk_wr($urandom_range(0, REGION - 1), $urandom_range(0, REGION - 1),
                   rand_height());
    end
    for (k = 0; k < 64; k++) begin
      if ($urandom_range(0, 9) < 3) begin
        w = mk_pt($urandom, $urandom, $urandom, $urandom);
      end else begin
        cx = $urandom_range(0, REGION - 2);
        cz = $urandom_range(0, REGION - 2);
        base = longint'(cloth_h[cz * MAX_COLS_DEF + cx]);
        w = mk_pt(aim(sh_org_x, sh_inv_x, cx),
                  32'(base + longint'($urandom_range(0, 131072)) - 65536),
                  aim(sh_org_z, sh_inv_z, cz), $urandom);
        if ($urandom_range(0, 9) == 0) w.point_y = $urandom;
      end
      if (corners_known(w)) return w;
    end
    // no safe point found for this setting: fall back to a height write
    return mk_wr($urandom_range(0, REGION - 1), $urandom_range(0, REGION - 1),
                 rand_height());
  endfunction

  // ------------------------------------------------------------------
  // Clock, reset
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Sender side. Called at a rising edge; returns at the accepting edge or after a random idle gap.
  // Handshakes are sampled on the falling edge, where all is settled.
  // ------------------------------------------------------------------
  task automatic push_word(input in_word_t w, input bit typed, input out_word_t texp);
    out_word_t r;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(negedge clk); while (!in_ready);
    if (classify(w, r)) begin
      pending_results.insert(pending_results.size(), typed ? texp : r);
      n_points++;
    end else begin
      n_writes++;
    end
    @(posedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Wait for every expected word plus the pipeline tail (a write in flight).
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ORIGIN_X:   sh_org_x = val;
      CFG_ORIGIN_Z:   sh_org_z = val;
      CFG_INV_STEP_X: sh_inv_x = val[30:0];
      CFG_INV_STEP_Z: sh_inv_z = val[30:0];
      CFG_THRESHOLD:  sh_thr   = val[30:0];
      CFG_GRID_COLS:  sh_cols  = val[7:0];
      CFG_GRID_ROWS:  sh_rows  = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [31:0] ox, input logic [31:0] oz,
                         input logic [31:0] ix, input logic [31:0] iz,
                         input logic [31:0] thr, input logic [31:0] cols,
                         input logic [31:0] rows);
    reg_write(CFG_ORIGIN_X, ox);
    reg_write(CFG_ORIGIN_Z, oz);
    reg_write(CFG_INV_STEP_X, ix);
    reg_write(CFG_INV_STEP_Z, iz);
    reg_write(CFG_THRESHOLD, thr);
    reg_write(CFG_GRID_COLS, cols);
    reg_write(CFG_GRID_ROWS, rows);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int k;
    for (k = 0; k < count; k++) push_word(next_word(), 1'b0, '0);
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t r;
  } dir_row_t;

  dir_row_t dir_tab[$];

  // append one row to the directed table
  function automatic void add_row(input in_word_t w, input bit typed,
                                  input out_word_t r);
    dir_row_t row;
    row.w     = w;
    row.typed = typed;
    row.r     = r;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  initial begin
    int r, c;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_ORIGIN_X;
    cfg_wdata = '0;
    errors = 0; n_points = 0; n_writes = 0; n_results = 0; n_oog = 0; n_ground = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    sh_org_x = '0; sh_org_z = '0;
    sh_inv_x = INV_STEP_RST; sh_inv_z = INV_STEP_RST;
    sh_thr = THRESHOLD_RST;
    sh_cols = GRID_DIM_RST; sh_rows = GRID_DIM_RST;
    for (int i = 0; i < NCELLS; i++) begin
      cloth_h[i]   = '0;
      cloth_set[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, reset configuration. Heights of 1.0 at the first cell.
    add_row(mk_wr(0, 0, 32'h0001_0000), 1'b0, '0);
    add_row(mk_wr(1, 0, 32'h0001_0000), 1'b0, '0);
    add_row(mk_wr(0, 1, 32'h0001_0000), 1'b0, '0);
    add_row(mk_wr(1, 1, 32'h0001_0000), 1'b0, '0);
    // flat cloth, y=0: diff 1.0, above the reset threshold of 0.5
    add_row(mk_pt(0, 0, 0, 16'd1), 1'b1, mk_res(16'd1, 0, 0, 32'h0001_0000));
    add_row(mk_pt(0, 32'h0001_0000, 0, 16'd2), 1'b1, mk_res(16'd2, 1, 0, 0));
    // left of the origin
    add_row(mk_pt(32'hFFFF_FFFF, 0, 0, 16'd3), 1'b1, mk_res(16'd3, 0, 1, 0));
    // last column has no right neighbor
    add_row(mk_pt(32'h007F_0000, 0, 0, 16'd4), 1'b1, mk_res(16'd4, 0, 1, 0));
    add_row(mk_pt(0, 0, 32'h8000_0000, 16'd5), 1'b1, mk_res(16'd5, 0, 1, 0));
    add_row(mk_pt(32'h7FFF_FFFF, 0, 0, 16'd9), 1'b1, mk_res(16'd9, 0, 1, 0));
    // saturation in both directions
    add_row(mk_wr(0, 0, 32'h7FFF_FFFF), 1'b0, '0);
    add_row(mk_pt(0, 32'h8000_0000, 0, 16'd6), 1'b1,
            mk_res(16'd6, 0, 0, 32'h7FFF_FFFF));
    add_row(mk_wr(0, 0, 32'h8000_0000), 1'b0, '0);
    add_row(mk_pt(0, 32'h7FFF_FFFF, 0, 16'd7), 1'b1,
            mk_res(16'd7, 0, 0, 32'h8000_0000));
    // fractional positions, checked by the predictor
    add_row(mk_wr(1, 1, 32'h0123_4567), 1'b0, '0);
    add_row(mk_pt(32'h0000_8000, 32'h0000_1000, 32'h0000_8000, 16'd8), 1'b0, '0);
    add_row(mk_pt(32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_FFFF, 16'hFFFF), 1'b0, '0);
    add_row(mk_wr(127, 127, 32'hDEAD_BEEF), 1'b0, '0);
    add_row(mk_wr(5, 3, 32'h8000_0001), 1'b0, '0);
    foreach (dir_tab[i]) push_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].r);

    // Preload the working region so every targeted point has known corners.
    for (r = 0; r < REGION; r++)
      for (c = 0; c < REGION; c++)
        push_word(mk_wr(c, r, rand_height()), 1'b0, '0);

    drain();
    set_all(0, 0, 32'd65536, 32'd65536, 32'd32768, 32'd12, 32'd12);
    hold_req = 1'b1;    // receiver stops for a while; input must back up
    run_random(200);

    // Extreme origins, smallest reciprocal step and zero threshold, smallest grid.
    drain();
    set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h8000_0001, 32'd0, 32'd2, 32'd2);
    run_random(180);

    // Largest reciprocal step, widest threshold, oversized grid registers clamp.
    drain();
    set_all(32'hFFF8_0000, 32'h0004_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
            32'h7FFF_FFFF, 32'd255, 32'd255);
    run_random(180);

    // Zero reciprocal steps: everything maps to the first cell.
    drain();
    set_all($urandom, $urandom, 32'd0, 32'h8000_0000, 32'd65536, 32'd12, 32'd12);
    run_random(120);

    // Grid registers too small: every point lands out of grid.
    drain();
    set_all(0, 0, 32'd65536, 32'd65536, 32'd32768, 32'd0, 32'd1);
    run_random(120);

    // Random scaled grid, full size.
    drain();
    set_all(32'(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000),
            32'(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000),
            $urandom_range(32'h1000, 32'h0010_0000), $urandom_range(32'h1000, 32'h0010_0000),
            $urandom_range(0, 32'h0004_0000), 32'd128, 32'd128);
    run_random(340);
    calm = 1'b1;        // closing stretch at full rate
    run_random(150);

    drain();
    $display("Covered %0d points (%0d out of grid, %0d ground) and %0d height writes",
             n_points, n_oog, n_ground, n_writes);
    $display("over seven register settings, with random stalls and a long output hold");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ------------------------------------------------------------------
  // Receiver side: random stall bursts, one long hold-off on request.
  // ------------------------------------------------------------------
  initial begin
    int hold_cnt;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < 400; hold_cnt++) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (calm || $urandom_range(0, 5) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Result checker and stall watchdog, both on the falling edge.
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.out_of_grid) n_oog++;
        if (want.is_ground) n_ground++;
        if (out_data.result_tag !== want.result_tag) begin
          errors++;
          $display("%0t: result_tag expected %h actual %h", $time,
                   want.result_tag, out_data.result_tag);
        end
        if (out_data.is_ground !== want.is_ground) begin
          errors++;
          $display("%0t: is_ground expected %b actual %b (tag %h)", $time,
                   want.is_ground, out_data.is_ground, want.result_tag);
        end
        if (out_data.out_of_grid !== want.out_of_grid) begin
          errors++;
          $display("%0t: out_of_grid expected %b actual %b (tag %h)", $time,
                   want.out_of_grid, out_data.out_of_grid, want.result_tag);
        end
        if (out_data.height_diff !== want.height_diff) begin
          errors++;
          $display("%0t: height_diff expected %h actual %h (tag %h)", $time,
                   want.height_diff, out_data.height_diff, want.result_tag);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;

endmodule
`default_nettype wire

// ----- grid_bilinear_ground_classifier.f -----
rtl/core/gbgc_pkg.sv
rtl/core/gbgc_ram.sv
rtl/core/gbgc_axis.sv
rtl/core/gbgc_lerp.sv
rtl/core/grid_bilinear_ground_classifier.sv
dv/tb_top.sv
